/* src/mfq_pkg.sv */
package mfq_pkg;

   // Sizing of the queue store.
   localparam int QUEUE_DEPTH  = 16;
   localparam int QUEUE_LEVELS = 3;
   localparam int IDX_W        = $clog2(QUEUE_DEPTH);
   localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int LVL_W        = $clog2(QUEUE_LEVELS);
   localparam int STORE_DEPTH  = QUEUE_LEVELS * QUEUE_DEPTH;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);

   // Field widths.
   localparam int ID_W       = 8;
   localparam int LEN_W      = 16;
   localparam int LEVEL_W    = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM_L0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY_L0  = 3'd3;

   // Action codes.
   localparam logic ACTION_ADMIT = 1'b0;
   localparam logic ACTION_RUN   = 1'b1;

   // Policy codes.
   localparam logic POLICY_FCFS = 1'b0;
   localparam logic POLICY_RR   = 1'b1;

   // Reset values of the per-level configuration.
   localparam logic [LEN_W-1:0] QUANTUM_RESET [3] = '{16'd4, 16'd8, 16'd8};
   localparam logic             POLICY_RESET  [3] = '{POLICY_RR, POLICY_RR, POLICY_FCFS};

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [LEN_W-1:0] left;
   } entry_type;

   typedef struct packed {
      logic               ran;
      logic [ID_W-1:0]    run_process_id;
      logic [LEN_W-1:0]   slice_length;
      logic [LEN_W-1:0]   remaining_after;
      logic               finished;
      logic [LEVEL_W-1:0] level_ran;
      logic [LEVEL_W-1:0] next_level;
      logic               idle;
      logic               admitted;
      logic               rejected_full;
   } result_type;

   // Flat store address of an index within a level.
   function automatic logic [ADDR_W-1:0] store_addr(input logic [LVL_W-1:0] lvl,
                                                    input logic [IDX_W-1:0] idx);
      store_addr = ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(idx);
   endfunction

   // Ring index increment.
   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
      if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
         idx_next = '0;
      end else begin
         idx_next = idx + 1'b1;
      end
   endfunction

endpackage

/* src/multilevel_feedback_queue_scheduler_unit.sv */
// Three-level feedback-queue scheduler.
// Input channel (req_*): an item is an admit (action 0) that puts a process id and
// burst length at the tail of level 0, or a run (action 1) that takes the head of the
// highest non-empty level and runs it for one slice. Each item gives one result item
// on the rsp_* channel; both channels move an item when valid is high and stall low.
// The csr_* port writes the per-level quantum (indexes 0..2) and policy (3..5); the user
// must write it only while no item is in flight; the block itself does not enforce this.
// One item is in flight at a time. An admit goes from acceptance straight to loading
// the output register; a run reads the head entry, then writes the demoted entry back,
// then loads the output register (an idle run loads it straight after acceptance).
// Results sit in an output register, so the next item is accepted while a result
// waits to be taken. If the receiver stalls while a second result is ready, the block
// holds it and stalls the input channel until the output register frees.
// Synchronous reset empties every level, clears the live count and restores the
// default quanta (4, 8, 8) and policies (round robin, round robin, first come first
// served). The queue store itself is not cleared; only occupied entries are read.
module multilevel_feedback_queue_scheduler_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_action,
   input  logic [mfq_pkg::ID_W-1:0]        req_process_id,
   input  logic [mfq_pkg::LEN_W-1:0]       req_burst_length,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_ran,
   output logic [mfq_pkg::ID_W-1:0]        rsp_run_process_id,
   output logic [mfq_pkg::LEN_W-1:0]       rsp_slice_length,
   output logic [mfq_pkg::LEN_W-1:0]       rsp_remaining_after,
   output logic                            rsp_finished,
   output logic [mfq_pkg::LEVEL_W-1:0]     rsp_level_ran,
   output logic [mfq_pkg::LEVEL_W-1:0]     rsp_next_level,
   output logic                            rsp_idle,
   output logic                            rsp_admitted,
   output logic                            rsp_rejected_full,
   input  logic                            csr_wr_en,
   input  logic [mfq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mfq_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mfq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] head_ff  [QUEUE_LEVELS];
   logic [IDX_W-1:0] head_in  [QUEUE_LEVELS];
   logic [IDX_W-1:0] tail_ff  [QUEUE_LEVELS];
   logic [IDX_W-1:0] tail_in  [QUEUE_LEVELS];
   logic [CNT_W-1:0] count_ff [QUEUE_LEVELS];
   logic [CNT_W-1:0] count_in [QUEUE_LEVELS];
   logic [CNT_W-1:0] live_ff, live_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   result_type       res_ff, res_in;
   result_type       rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0] quantum_ff [QUEUE_LEVELS];
   logic             policy_ff  [QUEUE_LEVELS];

   logic              accept;
   logic              found;
   logic [LVL_W-1:0]  sel;
   logic [LVL_W-1:0]  nxt;
   logic              full;
   logic [LEN_W-1:0]  slice;
   logic [LEN_W-1:0]  rest;
   entry_type         rd_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;

   mfq_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   // Highest-priority non-empty level.
   always_comb begin
      found = 1'b0;
      sel   = '0;
      for (int l = 0; l < QUEUE_LEVELS; l++) begin
         if (!found && count_ff[l] != '0) begin
            found = 1'b1;
            sel   = LVL_W'(l);
         end
      end
   end

   assign full = (live_ff >= CNT_W'(QUEUE_DEPTH)) || (count_ff[0] >= CNT_W'(QUEUE_DEPTH));

   // Slice of the entry read from the store and the level it goes to next.
   always_comb begin
      if (policy_ff[lvl_ff] == POLICY_RR && quantum_ff[lvl_ff] < rd_data.left) begin
         slice = quantum_ff[lvl_ff];
      end else begin
         slice = rd_data.left;
      end
      rest = rd_data.left - slice;
      if (lvl_ff == LVL_W'(QUEUE_LEVELS - 1)) begin
         nxt = lvl_ff;
      end else begin
         nxt = lvl_ff + 1'b1;
      end
   end

   // Sequencer: push or pop on acceptance, write back the demoted entry in the next cycle.
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      live_in      = live_ff;
      lvl_in       = lvl_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in   = '0;
               state_in = ST_DONE;
               if (req_action == ACTION_ADMIT) begin
                  if (full) begin
                     res_in.rejected_full = 1'b1;
                  end else begin
                     wr_en           = 1'b1;
                     wr_addr         = store_addr('0, tail_ff[0]);
                     wr_data.id      = req_process_id;
                     wr_data.left    = req_burst_length;
                     tail_in[0]      = idx_next(tail_ff[0]);
                     count_in[0]     = count_ff[0] + 1'b1;
                     live_in         = live_ff + 1'b1;
                     res_in.admitted = 1'b1;
                  end
               end else if (found) begin
                  rd_en         = 1'b1;
                  rd_addr       = store_addr(sel, head_ff[sel]);
                  head_in[sel]  = idx_next(head_ff[sel]);
                  count_in[sel] = count_ff[sel] - 1'b1;
                  lvl_in        = sel;
                  state_in      = ST_EXEC;
               end else begin
                  res_in.idle = 1'b1;
               end
            end
         end
         ST_EXEC: begin
            res_in.ran             = 1'b1;
            res_in.run_process_id  = rd_data.id;
            res_in.slice_length    = slice;
            res_in.remaining_after = rest;
            res_in.level_ran       = LEVEL_W'(lvl_ff);
            if (rest != '0) begin
               wr_en             = 1'b1;
               wr_addr           = store_addr(nxt, tail_ff[nxt]);
               wr_data.id        = rd_data.id;
               wr_data.left      = rest;
               tail_in[nxt]      = idx_next(tail_ff[nxt]);
               count_in[nxt]     = count_ff[nxt] + 1'b1;
               res_in.next_level = LEVEL_W'(nxt);
            end else begin
               res_in.finished = 1'b1;
               if (live_ff != '0) begin
                  live_in = live_ff - 1'b1;
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int l = 0; l < QUEUE_LEVELS; l++) begin
            head_ff[l]    <= '0;
            tail_ff[l]    <= '0;
            count_ff[l]   <= '0;
            quantum_ff[l] <= QUANTUM_RESET[l];
            policy_ff[l]  <= POLICY_RESET[l];
         end
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         if (csr_wr_en) begin
            for (int l = 0; l < QUEUE_LEVELS; l++) begin
               if (csr_index == CSR_QUANTUM_L0 + CSR_IDX_W'(l)) begin
                  quantum_ff[l] <= csr_wdata[LEN_W-1:0];
               end
               if (csr_index == CSR_POLICY_L0 + CSR_IDX_W'(l)) begin
                  policy_ff[l] <= csr_wdata[0];
               end
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      lvl_ff <= lvl_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ran             = rsp_ff.ran;
   assign rsp_run_process_id  = rsp_ff.run_process_id;
   assign rsp_slice_length    = rsp_ff.slice_length;
   assign rsp_remaining_after = rsp_ff.remaining_after;
   assign rsp_finished        = rsp_ff.finished;
   assign rsp_level_ran       = rsp_ff.level_ran;
   assign rsp_next_level      = rsp_ff.next_level;
   assign rsp_idle            = rsp_ff.idle;
   assign rsp_admitted        = rsp_ff.admitted;
   assign rsp_rejected_full   = rsp_ff.rejected_full;

endmodule

/* src/mfq_store.sv */
module mfq_store (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [mfq_pkg::ADDR_W-1:0] wr_addr,
   input  mfq_pkg::entry_type      wr_data,
   input  logic                    rd_en,
   input  logic [mfq_pkg::ADDR_W-1:0] rd_addr,
   output mfq_pkg::entry_type      rd_data
);
   import mfq_pkg::*;

   entry_type mem [STORE_DEPTH];
   entry_type rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
